[hw/rtl/source_text_tokenizer_assert.svh]
// assertion macros for the source text tokenizer
// both sample on clk and are disabled while rst_n is low
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stt assertion failed");

// next-cycle implication
`define STT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stt assertion failed");

`endif

[hw/rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Types, token codes and keyword table shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam logic [4:0] TT_LET      = 5'd0;
    localparam logic [4:0] TT_IDENT    = 5'd7;
    localparam logic [4:0] TT_NUMBER   = 5'd8;
    localparam logic [4:0] TT_LPAREN   = 5'd9;
    localparam logic [4:0] TT_RPAREN   = 5'd10;
    localparam logic [4:0] TT_LBRACE   = 5'd11;
    localparam logic [4:0] TT_RBRACE   = 5'd12;
    localparam logic [4:0] TT_LBRACKET = 5'd13;
    localparam logic [4:0] TT_RBRACKET = 5'd14;
    localparam logic [4:0] TT_BINOP    = 5'd15;
    localparam logic [4:0] TT_EQUALS   = 5'd16;
    localparam logic [4:0] TT_COLON    = 5'd17;
    localparam logic [4:0] TT_COMMA    = 5'd18;
    localparam logic [4:0] TT_SEMI     = 5'd19;
    localparam logic [4:0] TT_DOT      = 5'd20;
    localparam logic [4:0] TT_EOF      = 5'd21;
    localparam logic [4:0] TT_UNKNOWN  = 5'd22;
    // marks a byte with no single-character token
    localparam logic [4:0] TT_NONE     = TT_LET;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // keywords packed eight bits a letter, first letter highest
    localparam int KW_COUNT = 7;
    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        40'h00_00_6C_65_74,   // let
        40'h63_6F_6E_73_74,   // const
        40'h00_00_00_66_6E,   // fn
        40'h00_00_00_69_66,   // if
        40'h00_65_6C_73_65,   // else
        40'h00_00_66_6F_72,   // for
        40'h77_68_69_6C_65    // while
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd2, 3'd2, 3'd4, 3'd3, 3'd5
    };

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NUM,
        KIND_WORD
    } run_kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       byte_valid;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  token_type;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [7:0]  char_value;
        logic        last_of_run;
    } token_t;

    // all tokens caused by one transaction
    typedef struct packed {
        logic [1:0]       count;
        token_t [2:0]     toks;
    } bundle_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h0D);
    endfunction

    function automatic logic [4:0] single_type(logic [7:0] c);
        logic [4:0] t;
        case (c)
            8'h28: t = TT_LPAREN;
            8'h29: t = TT_RPAREN;
            8'h7B: t = TT_LBRACE;
            8'h7D: t = TT_RBRACE;
            8'h5B: t = TT_LBRACKET;
            8'h5D: t = TT_RBRACKET;
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25: t = TT_BINOP;
            8'h3D: t = TT_EQUALS;
            8'h3A: t = TT_COLON;
            8'h2C: t = TT_COMMA;
            8'h3B: t = TT_SEMI;
            8'h2E: t = TT_DOT;
            default: t = TT_NONE;
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/source_text_tokenizer.sv]
// an accepted byte is held in the input register; its tokens come from it combinationally
// and are loaded as one bundle into the output register, from which they are offered
// throughput: one byte per cycle; a byte with tokens waits in the input until the output
// is free; the single output register drains its bundle one token per cycle unless stalled
// reset (rst_n low, asynchronous) clears the position and run state and drops all work
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-serial lexer: input register, token logic, bundled result register.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS       = 16,
    parameter int KEYWORD_MAX_CHARS = 5
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  in_item_t src_data,
    output logic     tok_valid,
    input  logic     tok_stall,
    output token_t   tok_data
);

    logic     in_vld_reg, in_vld_next;
    in_item_t in_item_reg;
    logic     accept, go, load, out_free;
    bundle_t  bundle;

    // an item with no tokens goes through even while the output is busy
    assign go        = in_vld_reg && ((bundle.count == 2'd0) || out_free);
    assign load      = go && (bundle.count != 2'd0);
    assign src_stall = in_vld_reg && !go;
    assign accept    = src_valid && !src_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (go)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= src_data;
        end
    end

    stt_lex #(
        .OFFSET_BITS       (OFFSET_BITS),
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
    ) u_lex (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    stt_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (bundle),
        .stall  (tok_stall),
        .valid  (tok_valid),
        .data   (tok_data),
        .free   (out_free)
    );

    `STT_ASSERT_NOW(a_load_needs_room, load, out_free)
    `STT_ASSERT_NEXT(a_bundle_no_gap, tok_valid && !tok_stall && !tok_data.last_of_run, tok_valid)
    `STT_ASSERT_NOW(a_eof_closes, tok_valid && (tok_data.token_type == TT_EOF), tok_data.last_of_run && (tok_data.token_length == 16'd0))

endmodule

[hw/rtl/stt_lex.sv]
// ----------------------------------------------------------------------------
// stt_lex
// Run state registers and the token logic for one source byte per cycle while go is high.
// ----------------------------------------------------------------------------
module stt_lex
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS       = 16,
    parameter int KEYWORD_MAX_CHARS = 5
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     go,
    input  in_item_t item,
    output bundle_t  bundle
);

    localparam int WIN_W = 8 * KEYWORD_MAX_CHARS;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [15:0] KW_LIMIT = 16'(KEYWORD_MAX_CHARS);

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    run_kind_t              kind_reg, kind_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [15:0]            len_reg, len_next;
    logic [WIN_W-1:0]       win_reg, win_next;

    function automatic logic [4:0] run_type(run_kind_t k, logic [15:0] len,
                                            logic [WIN_W-1:0] win);
        logic [4:0] t;
        t = TT_IDENT;
        if (k == KIND_NUM)
        begin
            t = TT_NUMBER;
        end
        else if (len <= KW_LIMIT)
        begin
            for (int i = KW_COUNT - 1; i >= 0; i--)
            begin
                if ((len == 16'(KW_LEN[i])) && (win == WIN_W'(KW_TEXT[i])))
                begin
                    t = 5'(i);
                end
            end
        end
        return t;
    endfunction

    function automatic token_t make_tok(logic [4:0] tt, logic [OFFSET_BITS-1:0] start,
                                        logic [15:0] len, logic [7:0] cv);
        token_t t;
        t.token_type   = tt;
        t.start_offset = 16'(start);
        t.token_length = len;
        t.char_value   = cv;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    logic [7:0]             c;
    run_kind_t              kind_c;
    logic [4:0]             stype;
    logic [3:0]             cand_en;
    token_t [3:0]           cand;
    run_kind_t              k1;
    logic [OFFSET_BITS-1:0] s1, p1;
    logic [15:0]            l1;
    logic [WIN_W-1:0]       w1;
    logic [1:0]             cnt;

    always_comb
    begin
        c      = item.char_byte;
        kind_c = is_digit(c) ? KIND_NUM : (is_letter(c) ? KIND_WORD : KIND_NONE);
        stype  = single_type(c);

        // run closed by a byte of another class
        cand_en[0] = item.byte_valid && (kind_reg != KIND_NONE) && (kind_reg != kind_c);
        cand[0]    = make_tok(run_type(kind_reg, len_reg, win_reg), start_reg, len_reg, 8'h00);

        k1 = kind_reg;
        s1 = start_reg;
        l1 = len_reg;
        w1 = win_reg;
        p1 = pos_reg;
        if (item.byte_valid)
        begin
            if (cand_en[0])
            begin
                k1 = KIND_NONE;
                l1 = '0;
                w1 = '0;
            end
            if (kind_c != KIND_NONE)
            begin
                if (k1 == KIND_NONE)
                begin
                    k1 = kind_c;
                    s1 = pos_reg;
                    l1 = '0;
                    w1 = '0;
                end
                if ((kind_c == KIND_WORD) && (l1 < KW_LIMIT))
                begin
                    w1 = {w1[WIN_W-9:0], c};
                end
                if (l1 != LEN_MAX)
                begin
                    l1 = l1 + 16'd1;
                end
            end
            if (pos_reg != POS_MAX)
            begin
                p1 = pos_reg + OFFSET_BITS'(1);
            end
        end

        // the byte's own single-character token
        cand_en[1] = item.byte_valid && (kind_c == KIND_NONE) && !is_space(c);
        cand[1]    = make_tok((stype != TT_NONE) ? stype : TT_UNKNOWN, pos_reg, 16'd1, c);

        // end of source flushes the open run, then end of file
        cand_en[2] = item.end_of_source && (k1 != KIND_NONE);
        cand[2]    = make_tok(run_type(k1, l1, w1), s1, l1, 8'h00);
        cand_en[3] = item.end_of_source;
        cand[3]    = make_tok(TT_EOF, p1, 16'd0, 8'h00);

        bundle = '0;
        cnt    = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_en[i] && (cnt != 2'd3))
            begin
                bundle.toks[cnt] = cand[i];
                cnt = cnt + 2'd1;
            end
        end
        bundle.count = cnt;
        if (cnt != 2'd0)
        begin
            bundle.toks[cnt - 2'd1].last_of_run = 1'b1;
        end

        if (item.end_of_source)
        begin
            pos_next   = '0;
            kind_next  = KIND_NONE;
            start_next = '0;
            len_next   = '0;
            win_next   = '0;
        end
        else
        begin
            pos_next   = p1;
            kind_next  = k1;
            start_next = s1;
            len_next   = l1;
            win_next   = w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            kind_reg  <= KIND_NONE;
            start_reg <= '0;
            len_reg   <= '0;
            win_reg   <= '0;
        end
        else if (go)
        begin
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            win_reg   <= win_next;
        end
    end

endmodule

[hw/rtl/stt_out.sv]
// ----------------------------------------------------------------------------
// stt_out
// Result register holding one token bundle, drained one token per transaction.
// ----------------------------------------------------------------------------
module stt_out
    import stt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  bundle_t bundle,
    input  logic    stall,
    output logic    valid,
    output token_t  data,
    output logic    free
);

    logic       vld_reg, vld_next;
    logic [1:0] idx_reg, idx_next;
    bundle_t    bnd_reg;
    logic       take, at_last;

    assign take    = vld_reg && !stall;
    assign at_last = (idx_reg == (bnd_reg.count - 2'd1));
    // room for a new bundle once the last token leaves
    assign free    = !vld_reg || (take && at_last);
    assign valid   = vld_reg;
    assign data    = bnd_reg.toks[idx_reg];

    always_comb
    begin
        vld_next = vld_reg;
        idx_next = idx_reg;
        if (load)
        begin
            vld_next = 1'b1;
            idx_next = '0;
        end
        else if (take)
        begin
            if (at_last)
            begin
                vld_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bnd_reg <= bundle;
        end
    end

endmodule
